@@ rtl/iee_pkg.sv @@
// shared types and codes for the infix expression evaluator
// no dependencies
package iee_pkg;

    typedef enum logic [2:0] {
        OP_LPAR = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_POW  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OPERAND  = 3'd1,
        ST_LBRACKET = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_LEFTOVER = 3'd4,
        ST_DIVZERO  = 3'd5,
        ST_OVERFLOW = 3'd6,
        ST_BADCHAR  = 3'd7
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,     // wait for a request
        S_CHAR,     // decide what the character does
        S_OPRD,     // operator top read issued
        S_OPCHK,    // look at the operator top
        S_VRD1,     // b arrives, read a
        S_VARG,     // a arrives
        S_MUL,      // multiply or power step
        S_DIV,      // one quotient bit a cycle
        S_PUSHR,    // push result
        S_FINRD,    // read bottom value for answer
        S_FINV,     // answer arrives
        S_DONE      // result held until taken
    } t_state;

    // what the current character asks for while reducing
    typedef enum logic [2:0] {
        M_RPAR,
        M_MULDIV,
        M_ADDSUB,
        M_FINISH
    } t_mode;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

@@ rtl/infix_expression_evaluator.sv @@
// infix expression evaluator: value and operator stacks in block memories
// a character that ends a literal first pushes the literal; + - * / reduce stacked
// operators of equal or higher rank, ) and the zero byte reduce down to the bracket or
// bottom; *, / and ^ iterate (not for a negative exponent); the zero byte reads out
// throughput: one request at a time; the sequencer sets the rate
// reset: synchronous active low, clears counts, error and sequencer; stacks unset
module infix_expression_evaluator import iee_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_character,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_answer,
    output logic [2:0]         o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    // stacks
    logic [31:0] r_vmem [STACK_DEPTH];
    logic [2:0]  r_omem [STACK_DEPTH];
    logic [31:0] r_vrd;
    logic [2:0]  r_ord;
    logic        vwe, vre, owe, ore;
    logic [AW-1:0] vwa, vra, owa, ora;
    logic [31:0] vwd;
    logic [2:0]  owd;

    always_ff @(posedge i_clk) begin
        if (vwe) r_vmem[vwa] <= vwd;
        if (vre) r_vrd <= r_vmem[vra];
        if (owe) r_omem[owa] <= owd;
        if (ore) r_ord <= r_omem[ora];
    end

    t_state r_state, n_state;
    t_mode r_mode, n_mode;
    logic [CW-1:0] r_vcnt, n_vcnt, r_ocnt, n_ocnt;
    logic [31:0] r_acc, n_acc;
    logic r_innum, n_innum;
    t_status r_err, n_err;
    logic [7:0] r_ch, n_ch;
    logic [2:0] r_op, n_op;
    logic [31:0] r_a, n_a, r_b, n_b, r_res, n_res;
    logic [5:0] r_k, n_k;
    logic [31:0] r_rem, n_rem;
    logic r_neg, n_neg;
    logic [31:0] r_ans, n_ans;
    t_status r_st, n_st;
    logic r_flushed, n_flushed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt <= '0;
            r_ocnt <= '0;
            r_innum <= 1'b0;
            r_err <= ST_OK;
            r_acc <= '0;
        end else begin
            r_state <= n_state;
            r_vcnt <= n_vcnt;
            r_ocnt <= n_ocnt;
            r_innum <= n_innum;
            r_err <= n_err;
            r_acc <= n_acc;
        end
        r_mode <= n_mode; r_ch <= n_ch; r_op <= n_op;
        r_a <= n_a; r_b <= n_b; r_res <= n_res; r_k <= n_k;
        r_rem <= n_rem; r_neg <= n_neg; r_ans <= n_ans; r_st <= n_st;
        r_flushed <= n_flushed;
    end

    // handshake outputs
    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
        o_answer = r_ans;
        o_status = r_st;
    end

    logic is_digit;
    logic [31:0] b_mag, sub_try;
    logic [32:0] rem_sh;
    logic [63:0] prod;
    assign is_digit = (r_ch >= CH_0) && (r_ch <= CH_9);
    assign b_mag = r_b[31] ? (32'd0 - r_b) : r_b;
    assign rem_sh = {r_rem, r_a[31]};
    assign sub_try = rem_sh[31:0] - r_b;

    // sequencer
    always_comb begin
        n_state = r_state; n_mode = r_mode; n_vcnt = r_vcnt; n_ocnt = r_ocnt;
        n_acc = r_acc; n_innum = r_innum; n_err = r_err; n_ch = r_ch; n_op = r_op;
        n_a = r_a; n_b = r_b; n_res = r_res; n_k = r_k; n_rem = r_rem;
        n_neg = r_neg; n_ans = r_ans; n_st = r_st; n_flushed = r_flushed;
        vwe = 1'b0; vre = 1'b0; owe = 1'b0; ore = 1'b0;
        vwa = '0; vra = '0; owa = '0; ora = '0; vwd = '0; owd = '0;
        prod = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ch = i_character;
                    n_flushed = 1'b0;
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                if (r_ch != CH_NUL && r_err != ST_OK) begin
                    n_state = S_IDLE;
                end else if (r_ch == CH_NUL && r_err != ST_OK) begin
                    n_ans = '0; n_st = r_err; n_state = S_DONE;
                end else if (is_digit) begin
                    n_acc = r_innum ? 32'(r_acc * 32'd10 + 32'(r_ch - CH_0))
                                    : 32'(r_ch - CH_0);
                    n_innum = 1'b1;
                    n_state = S_IDLE;
                end else if (r_innum && !r_flushed) begin
                    // flush the literal first
                    n_innum = 1'b0;
                    n_flushed = 1'b1;
                    if (r_vcnt >= DEPTH_C) begin
                        n_err = ST_OVERFLOW;
                        if (r_ch == CH_NUL) begin
                            n_ans = '0; n_st = ST_OVERFLOW; n_state = S_DONE;
                        end else n_state = S_IDLE;
                    end else begin
                        vwe = 1'b1; vwa = AW'(r_vcnt); vwd = r_acc;
                        n_vcnt = r_vcnt + ONE_C;
                    end
                end else begin
                    n_flushed = 1'b1;
                    case (r_ch)
                        CH_SPACE: n_state = S_IDLE;
                        CH_LPAR, CH_CARET: begin
                            if (r_ocnt >= DEPTH_C) n_err = ST_OVERFLOW;
                            else begin
                                owe = 1'b1; owa = AW'(r_ocnt);
                                owd = (r_ch == CH_LPAR) ? OP_LPAR : OP_POW;
                                n_ocnt = r_ocnt + ONE_C;
                            end
                            n_state = S_IDLE;
                        end
                        CH_RPAR, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_NUL: begin
                            case (r_ch)
                                CH_RPAR:  n_mode = M_RPAR;
                                CH_STAR, CH_SLASH: n_mode = M_MULDIV;
                                CH_PLUS, CH_MINUS: n_mode = M_ADDSUB;
                                default:  n_mode = M_FINISH;
                            endcase
                            n_state = S_OPRD;
                        end
                        default: begin
                            n_err = ST_BADCHAR;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_OPRD: begin
                if (r_ocnt == '0) begin
                    case (r_mode)
                        M_RPAR: begin n_err = ST_LBRACKET; n_state = S_IDLE; end
                        M_FINISH: begin
                            if (r_vcnt == '0) begin
                                n_ans = '0; n_st = ST_EMPTY; n_state = S_DONE;
                            end else if (r_vcnt > ONE_C) begin
                                n_ans = '0; n_st = ST_LEFTOVER; n_state = S_DONE;
                            end else begin
                                vre = 1'b1; vra = '0; n_state = S_FINRD;
                            end
                        end
                        default: begin
                            // push the new operator
                            if (r_ocnt >= DEPTH_C) n_err = ST_OVERFLOW;
                            else begin
                                owe = 1'b1; owa = AW'(r_ocnt);
                                case (r_ch)
                                    CH_STAR:  owd = OP_MUL;
                                    CH_SLASH: owd = OP_DIV;
                                    CH_PLUS:  owd = OP_ADD;
                                    default:  owd = OP_SUB;
                                endcase
                                n_ocnt = r_ocnt + ONE_C;
                            end
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    ore = 1'b1; ora = AW'(r_ocnt - ONE_C);
                    n_state = S_OPCHK;
                end
            end
            S_OPCHK: begin
                n_op = r_ord;
                if ((r_mode == M_MULDIV && r_ord < OP_MUL) ||
                    (r_mode == M_ADDSUB && r_ord == OP_LPAR)) begin
                    // stop reducing, push the new operator
                    if (r_ocnt >= DEPTH_C) n_err = ST_OVERFLOW;
                    else begin
                        owe = 1'b1; owa = AW'(r_ocnt);
                        case (r_ch)
                            CH_STAR:  owd = OP_MUL;
                            CH_SLASH: owd = OP_DIV;
                            CH_PLUS:  owd = OP_ADD;
                            default:  owd = OP_SUB;
                        endcase
                        n_ocnt = r_ocnt + ONE_C;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_ocnt = r_ocnt - ONE_C;
                    if (r_ord == OP_LPAR) begin
                        n_state = (r_mode == M_RPAR) ? S_IDLE : S_OPRD;
                    end else if (r_vcnt < TWO_C) begin
                        n_err = ST_OPERAND;
                        if (r_mode == M_FINISH) begin
                            n_ans = '0; n_st = ST_OPERAND; n_state = S_DONE;
                        end else n_state = S_IDLE;
                    end else begin
                        vre = 1'b1; vra = AW'(r_vcnt - ONE_C);
                        n_state = S_VRD1;
                    end
                end
            end
            S_VRD1: begin
                // b arrives, read a
                n_b = r_vrd;
                vre = 1'b1; vra = AW'(r_vcnt - TWO_C);
                n_state = S_VARG;
            end
            S_VARG: begin
                n_a = r_vrd;
                n_vcnt = r_vcnt - TWO_C;
                n_k = '0;
                case (t_op'(r_op))
                    OP_ADD: begin n_res = r_vrd + r_b; n_state = S_PUSHR; end
                    OP_SUB: begin n_res = r_vrd - r_b; n_state = S_PUSHR; end
                    OP_MUL: begin
                        n_res = '0; n_state = S_MUL;
                    end
                    OP_DIV: begin
                        if (r_b == '0) begin
                            n_err = ST_DIVZERO;
                            if (r_mode == M_FINISH) begin
                                n_ans = '0; n_st = ST_DIVZERO; n_state = S_DONE;
                            end else n_state = S_IDLE;
                        end else begin
                            n_neg = r_vrd[31] ^ r_b[31];
                            n_a = r_vrd[31] ? (32'd0 - r_vrd) : r_vrd;
                            n_b = b_mag; n_rem = '0; n_state = S_DIV;
                        end
                    end
                    default: begin
                        // power: negative exponent special cases
                        if (r_b[31]) begin
                            if (r_vrd == 32'd1) n_res = 32'd1;
                            else if (r_vrd == 32'hffff_ffff)
                                n_res = r_b[0] ? 32'hffff_ffff : 32'd1;
                            else n_res = '0;
                            n_state = S_PUSHR;
                        end else begin
                            n_res = 32'd1; n_state = S_MUL;
                        end
                    end
                endcase
            end
            S_MUL: begin
                // multiply: shift-add over b; power: square and multiply
                n_k = r_k + 6'd1;
                if (r_op == OP_MUL) begin
                    if (r_b[r_k[4:0]]) n_res = r_res + (r_a << r_k[4:0]);
                end else begin
                    if (r_k[0] == 1'b0) begin
                        if (r_b[0]) begin
                            prod = r_res * r_a; n_res = prod[31:0];
                        end
                    end else begin
                        prod = r_a * r_a; n_a = prod[31:0];
                        n_b = r_b >> 1;
                    end
                end
                if ((r_op == OP_MUL && r_k == 6'd31) ||
                    (r_op != OP_MUL && r_k == 6'd61)) n_state = S_PUSHR;
            end
            S_DIV: begin
                n_a = r_a << 1;
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = sub_try; n_res = {r_res[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[31:0]; n_res = {r_res[30:0], 1'b0};
                end
                n_k = r_k + 6'd1;
                if (r_k == 6'd31) n_state = S_PUSHR;
            end
            S_PUSHR: begin
                // vcnt is at most depth minus two here, so the push always fits
                vwe = 1'b1; vwa = AW'(r_vcnt);
                vwd = (r_op == OP_DIV && r_neg) ? (32'd0 - r_res) : r_res;
                n_vcnt = r_vcnt + ONE_C;
                n_state = (r_mode == M_RPAR || r_mode == M_FINISH ||
                           r_mode == M_MULDIV || r_mode == M_ADDSUB) ? S_OPRD : S_IDLE;
            end
            S_FINRD: n_state = S_FINV;
            S_FINV: begin
                n_ans = r_vrd; n_st = ST_OK; n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                    n_vcnt = '0; n_ocnt = '0; n_acc = '0; n_innum = 1'b0;
                    n_err = ST_OK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/iee_checker.sv @@
// port checker for the infix expression evaluator
// depends on iee_pkg; bound to infix_expression_evaluator
module iee_checker import iee_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_answer,
    input logic [2:0]  o_status
);
    // a failing status always carries a zero answer
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_answer == '0) else $error("answer");
    // no request taken while a result is shown
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("stall");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_answer) && $stable(o_status))
        else $error("hold");
    // an accepted request keeps the input stalled on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("busy");
endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for the infix expression evaluator
// feeds character requests, predicts each zero-byte result, compares in order
// depends on iee_pkg and infix_expression_evaluator
module tb_top;
    import iee_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_character = CH_NUL;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [31:0] o_answer;
    logic [2:0]        o_status;

    infix_expression_evaluator #(.STACK_DEPTH(DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_character(i_character), .o_valid(o_valid), .i_stall(i_stall),
        .o_answer(o_answer), .o_status(o_status)
    );

    typedef struct packed {
        logic [31:0] answer;
        logic [2:0]  status;
    } t_result;

    // clock
    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] vals [DEPTH];
    t_op         ops [DEPTH];
    int          nval, nop;
    logic [31:0] acc;
    bit          in_num;
    t_status     err_first;

    logic [7:0]  char_q [$];
    t_result     result_q [$];
    int          errors = 0;
    int          n_chars = 0;
    int          n_results = 0;
    bit          stim_done = 0;
    bit          hold_long = 0;
    int          status_seen [8];

    function automatic void clear_eval();
        nval = 0; nop = 0; acc = 0; in_num = 0; err_first = ST_OK;
    endfunction

    function automatic logic [31:0] pow32(logic [31:0] base, logic [31:0] ex);
        logic [31:0] r;
        r = 32'd1;
        if (ex[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hffff_ffff) return ex[0] ? 32'hffff_ffff : 32'd1;
            return 32'd0;
        end
        for (int i = 0; i < 31; i++) begin
            if (ex[0]) r = r * base;
            base = base * base;
            ex = ex >> 1;
        end
        return r;
    endfunction

    function automatic t_status push_val(logic [31:0] v);
        if (nval >= DEPTH) return ST_OVERFLOW;
        vals[nval] = v; nval++;
        return ST_OK;
    endfunction

    function automatic t_status push_op(t_op op);
        if (nop >= DEPTH) return ST_OVERFLOW;
        ops[nop] = op; nop++;
        return ST_OK;
    endfunction

    function automatic t_status reduce(t_op op);
        logic [31:0] a, b, r, ma, mb, q;
        if (nval < 2) return ST_OPERAND;
        nval--; b = vals[nval];
        nval--; a = vals[nval];
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
                if (b == 0) return ST_DIVZERO;
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                r = (a[31] ^ b[31]) ? -q : q;
            end
            OP_POW: r = pow32(a, b);
            default: r = 0;
        endcase
        return push_val(r);
    endfunction

    function automatic t_status flush_lit();
        if (!in_num) return ST_OK;
        in_num = 0;
        return push_val(acc);
    endfunction

    function automatic t_status eval_char(logic [7:0] c);
        t_status e;
        t_op op;
        if (c >= CH_0 && c <= CH_9) begin
            acc = in_num ? acc * 32'd10 + 32'(c - CH_0) : 32'(c - CH_0);
            in_num = 1;
            return ST_OK;
        end
        e = flush_lit();
        if (e != ST_OK) return e;
        case (c)
            CH_SPACE: return ST_OK;
            CH_LPAR:  return push_op(OP_LPAR);
            CH_RPAR: begin
                while (nop > 0) begin
                    nop--; op = ops[nop];
                    if (op == OP_LPAR) return ST_OK;
                    e = reduce(op);
                    if (e != ST_OK) return e;
                end
                return ST_LBRACKET;
            end
            CH_CARET: return push_op(OP_POW);
            CH_STAR, CH_SLASH: begin
                while (nop > 0 && ops[nop-1] >= OP_MUL) begin
                    nop--;
                    e = reduce(ops[nop]);
                    if (e != ST_OK) return e;
                end
                return push_op(c == CH_STAR ? OP_MUL : OP_DIV);
            end
            CH_PLUS, CH_MINUS: begin
                while (nop > 0 && ops[nop-1] != OP_LPAR) begin
                    nop--;
                    e = reduce(ops[nop]);
                    if (e != ST_OK) return e;
                end
                return push_op(c == CH_PLUS ? OP_ADD : OP_SUB);
            end
            default: return ST_BADCHAR;
        endcase
    endfunction

    function automatic t_result finish_expr();
        t_result res;
        t_status e;
        t_op op;
        res = '0;
        e = err_first;
        if (e == ST_OK) e = flush_lit();
        while (e == ST_OK && nop > 0) begin
            nop--; op = ops[nop];
            if (op != OP_LPAR) e = reduce(op);
        end
        if (e == ST_OK && nval == 0) e = ST_EMPTY;
        if (e == ST_OK && nval > 1) e = ST_LEFTOVER;
        if (e == ST_OK) res.answer = vals[0];
        res.status = e;
        return res;
    endfunction

    // predict on every accepted request
    function automatic void predict(logic [7:0] c);
        if (c == CH_NUL) begin
            result_q.push_back(finish_expr());
            clear_eval();
        end else if (err_first == ST_OK) begin
            err_first = eval_char(c);
        end
    endfunction

    // stimulus helpers
    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
        char_q.push_back(CH_NUL);
    endtask

    function automatic string rnd_lit();
        case ($urandom_range(0, 9))
            0: return "0";
            1: return "1";
            2: return "4294967295";
            3: return "2147483648";
            default: return $sformatf("%0d", $urandom_range(0, 99));
        endcase
    endfunction

    function automatic string rnd_expr(int lvl);
        string s, opc;
        int n;
        n = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                case ($urandom_range(0, 4))
                    0: opc = "+"; 1: opc = "-"; 2: opc = "*";
                    3: opc = "/"; default: opc = "^";
                endcase
                if ($urandom_range(0, 3) == 0) s = {s, " "};
                s = {s, opc};
            end
            if (lvl < 3 && $urandom_range(0, 3) == 0)
                s = {s, "(", rnd_expr(lvl + 1), ")"};
            else
                s = {s, rnd_lit()};
        end
        return s;
    endfunction

    function automatic string mangle(string s);
        string t;
        byte junk;
        t = s;
        if (t.len() > 0) begin
            case ($urandom_range(0, 2))
                0: junk = byte'($urandom_range(1, 255));
                1: junk = ")";
                default: junk = "+";
            endcase
            t.putc($urandom_range(0, t.len() - 1), junk);
        end
        return t;
    endfunction

    // stimulus
    initial begin
        string s;
        clear_eval();
        put_str("0");
        put_str("4294967295");
        put_str("1+2*3");
        put_str("12 34");
        put_str("7-10/3");
        put_str("2^3^2");
        put_str("(1+2)*3");
        put_str("2147483648/4294967295");
        put_str("-7/2");
        put_str("5/0");
        put_str("0^0");
        put_str("3^4294967295");
        put_str("1^4294967295");
        put_str("4294967295^4294967295");
        put_str("4294967295^4294967294");
        put_str("1+");
        put_str("1)");
        put_str("((2+3");
        put_str("");
        put_str("   ");
        put_str("2 3 4");
        put_str("1&2");
        char_q.push_back(8'hff);
        char_q.push_back(CH_NUL);
        s = "";
        for (int i = 0; i < 33; i++) s = {s, "("};
        put_str(s);
        s = "";
        for (int i = 0; i < 33; i++) s = {s, "1 "};
        put_str(s);
        // random expressions until at least 860 characters are queued in all
        while (char_q.size() < 860) begin
            s = rnd_expr(0);
            if ($urandom_range(0, 7) == 0) s = mangle(s);
            put_str(s);
        end
        // random nonzero bytes
        for (int i = 0; i < 40; i++) char_q.push_back(8'($urandom_range(1, 255)));
        char_q.push_back(CH_NUL);
    end

    // driver
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict(i_character);
                n_chars++;
            end
            if (gap > 0) begin
                gap--;
                i_valid <= 1'b0;
            end else if (char_q.size() > 0) begin
                i_valid     <= 1'b1;
                i_character <= char_q.pop_front();
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                    : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
            end else begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // monitor and receiver stall
    int hold_cnt = 0;
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result answer=%0d status=%0d",
                             $time, o_answer, o_status);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    n_results++;
                    status_seen[o_status]++;
                    if (o_answer !== exp_r.answer)
                        $display("%0t: answer expected %0d actual %0d", $time,
                                 $signed(exp_r.answer), o_answer);
                    if (o_status !== exp_r.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, o_status);
                    if (o_answer !== exp_r.answer || o_status !== exp_r.status)
                        errors++;
                end
            end
            // long hold-off once, early in the random part
            if (n_chars == 300 && !hold_long) begin
                hold_long <= 1'b1;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (n_results > 100 && $urandom_range(0, 7) == 0)
                    rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                           : $urandom_range(1, 3);
            end
        end
    end

    // reset, end of run
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (result_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("run covered %0d characters and %0d results", n_chars, n_results);
        $display("status counts ok..badchar: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (errors == 0)
            $display("** infix_expression_evaluator: PASSED **");
        else
            $display("** infix_expression_evaluator: FAILED **");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("** infix_expression_evaluator: FAILED **");
        $finish;
    end
endmodule
